// File: sv/stq_pkg.sv
// Shared types and codes for the sorted timer event queue.
// Request and status codes, and the per-cell operation driven along the chain.
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_POP    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_PAST  = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP,
		CELL_REMOVE
	} cell_op_t;

endpackage
`default_nettype wire

// File: sv/stq_cell.sv
// One slot of the sorted queue: holds an id and a wake time.
// Takes from its left or right neighbor as the chain operation directs; uses stq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stq_cell #(
	parameter int ID_BITS   = 8,
	parameter int TIME_BITS = 48
) (
	input  wire                   clk,
	input  stq_pkg::cell_op_t     op,
	input  wire                   valid,
	input  wire [ID_BITS-1:0]     in_id,
	input  wire [TIME_BITS-1:0]   in_time,
	input  wire [ID_BITS-1:0]     rm_id,
	input  wire [ID_BITS-1:0]     left_id,
	input  wire [TIME_BITS-1:0]   left_time,
	input  wire [ID_BITS-1:0]     right_id,
	input  wire [TIME_BITS-1:0]   right_time,
	input  wire                   left_after,
	input  wire                   left_hit,
	output logic                  after,
	output logic                  hit,
	output logic [ID_BITS-1:0]    cell_id,
	output logic [TIME_BITS-1:0]  cell_time
);
	import stq_pkg::*;

	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] time_q;
	logic [ID_BITS-1:0]   id_d;
	logic [TIME_BITS-1:0] time_d;

	// Slot lies at or past the insert point: empty, or strictly later than the new timer.
	assign after = !valid || (time_q > in_time);
	// Some slot at or before this one matches the id being removed.
	assign hit = left_hit || (valid && (id_q == rm_id));

	always_comb begin
		id_d   = id_q;
		time_d = time_q;
		unique case (op)
			CELL_INSERT: begin
				if (after && !left_after) begin
					id_d   = in_id;
					time_d = in_time;
				end else if (left_after) begin
					id_d   = left_id;
					time_d = left_time;
				end
			end
			CELL_POP: begin
				id_d   = right_id;
				time_d = right_time;
			end
			CELL_REMOVE: begin
				if (hit) begin
					id_d   = right_id;
					time_d = right_time;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		id_q   <= id_d;
		time_q <= time_d;
	end

	assign cell_id   = id_q;
	assign cell_time = time_q;

endmodule
`default_nettype wire

// File: sv/sorted_timer_event_queue.sv
// Sorted timer event queue: insert and pop complete in the cycle after the transfer;
// remove drops one matching entry per cycle through the cell chain.
// Insert, pop and unused requests: result in the cycle after start, busy stays low, 1 per cycle.
// Remove: busy while matching entries are dropped; done rises in the same cycle busy falls,
// so the next transfer can be accepted while done is high.
// Reset clears the entry count and the virtual clock (the epoch); slot contents are kept.
// Results are strobed on done for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module sorted_timer_event_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8,
	parameter int TIME_BITS   = 48,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire [1:0]             req_type,
	input  wire [ID_BITS-1:0]     timer_id,
	input  wire [TIME_BITS-1:0]   alarm_time,
	output logic                  done,
	output logic [1:0]            status,
	output logic [ID_BITS-1:0]    fired_id,
	output logic [TIME_BITS-1:0]  fired_time,
	output logic [TIME_BITS-1:0]  now_time,
	output logic [CNT_W-1:0]      removed_count,
	output logic [CNT_W-1:0]      occupancy
);
	import stq_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] clock_q;
	logic [ID_BITS-1:0]   rm_id_q;
	logic [CNT_W-1:0]     rm_cnt_q;

	logic [ID_BITS-1:0]   cid   [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] ctime [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0] after_c;
	logic [QUEUE_DEPTH:0] hit_c;
	cell_op_t             op;

	logic accept;
	logic full;
	logic empty;
	logic any_hit;
	logic past;

	assign accept  = start && !busy_q;
	assign full    = (count_q == DEPTH_CNT);
	assign empty   = (count_q == '0);
	assign any_hit = hit_c[QUEUE_DEPTH];
	assign past    = (ctime[0] < clock_q);

	assign after_c[0] = 1'b0;
	assign hit_c[0]   = 1'b0;

	always_comb begin
		op = CELL_HOLD;
		if (busy_q) begin
			if (any_hit)
				op = CELL_REMOVE;
		end else if (start) begin
			if (req_type == REQ_INSERT && !full)
				op = CELL_INSERT;
			else if (req_type == REQ_POP && !empty)
				op = CELL_POP;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		logic [ID_BITS-1:0]   l_id;
		logic [TIME_BITS-1:0] l_time;
		logic [ID_BITS-1:0]   r_id;
		logic [TIME_BITS-1:0] r_time;

		if (i == 0) begin : g_first
			assign l_id   = '0;
			assign l_time = '0;
		end else begin : g_mid_l
			assign l_id   = cid[i-1];
			assign l_time = ctime[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_id   = '0;
			assign r_time = '0;
		end else begin : g_mid_r
			assign r_id   = cid[i+1];
			assign r_time = ctime[i+1];
		end

		stq_cell #(
			.ID_BITS   (ID_BITS),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.valid      (IDX < count_q),
			.in_id      (timer_id),
			.in_time    (alarm_time),
			.rm_id      (rm_id_q),
			.left_id    (l_id),
			.left_time  (l_time),
			.right_id   (r_id),
			.right_time (r_time),
			.left_after (after_c[i]),
			.left_hit   (hit_c[i]),
			.after      (after_c[i+1]),
			.hit        (hit_c[i+1]),
			.cell_id    (cid[i]),
			.cell_time  (ctime[i])
		);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
			clock_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (any_hit) begin
					count_q <= count_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				unique case (req_type)
					REQ_INSERT: begin
						done_q <= 1'b1;
						if (!full)
							count_q <= count_q + 1'b1;
					end
					REQ_REMOVE: begin
						busy_q <= 1'b1;
					end
					REQ_POP: begin
						done_q <= 1'b1;
						if (!empty) begin
							count_q <= count_q - 1'b1;
							if (!past)
								clock_q <= ctime[0];
						end
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// Remove bookkeeping and result payload.
	always_ff @(posedge clk) begin
		if (accept)
			rm_id_q <= timer_id;
		if (accept)
			rm_cnt_q <= '0;
		else if (busy_q && any_hit)
			rm_cnt_q <= rm_cnt_q + 1'b1;

		if (busy_q && !any_hit) begin
			status        <= ST_OK;
			fired_id      <= '0;
			fired_time    <= '0;
			now_time      <= clock_q;
			removed_count <= rm_cnt_q;
			occupancy     <= count_q;
		end else if (accept) begin
			status        <= ST_OK;
			fired_id      <= '0;
			fired_time    <= '0;
			now_time      <= clock_q;
			removed_count <= '0;
			occupancy     <= count_q;
			unique case (req_type)
				REQ_INSERT: begin
					if (full)
						status <= ST_FULL;
					else
						occupancy <= count_q + 1'b1;
				end
				REQ_POP: begin
					if (empty) begin
						status <= ST_EMPTY;
					end else begin
						fired_id   <= cid[0];
						fired_time <= ctime[0];
						occupancy  <= count_q - 1'b1;
						if (past)
							status <= ST_PAST;
						else
							now_time <= ctime[0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule
`default_nettype wire
